### rtl/bracket_balance_checker_assert.svh
// Assertion macros for the RTL file that checks itself.
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Whenever the antecedent holds at a clock edge, the consequent holds at the same edge.
`define BBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Whenever the antecedent holds at a clock edge, the consequent holds at the next edge.
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/bbc_pkg.sv
package bbc_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;

    localparam logic [1:0] BR_PAREN  = 2'd0;
    localparam logic [1:0] BR_SQUARE = 2'd1;
    localparam logic [1:0] BR_CURLY  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MATCHED     = 3'd1,
        ST_CLOSE_EMPTY = 3'd2,
        ST_MISMATCH    = 3'd3,
        ST_UNCLOSED    = 3'd4,
        ST_OVERFLOW    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        K_OTHER,
        K_NEWLINE,
        K_OPEN,
        K_CLOSE,
        K_EOT
    } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             status;
        logic [7:0]             offending_char;
        logic [LINE_BITS-1:0]   line_no;
        logic [COLUMN_BITS-1:0] column_no;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] code;
        logic [7:0] ch;
    } t_cmd;

    function automatic t_cmd classify(t_in_item item);
        t_cmd cmd;
        cmd.kind = K_OTHER;
        cmd.code = BR_PAREN;
        cmd.ch   = item.text_byte;
        if (item.end_of_text) begin
            cmd.kind = K_EOT;
        end else begin
            case (item.text_byte)
                CH_NEWLINE: cmd.kind = K_NEWLINE;
                CH_LPAREN: begin
                    cmd.kind = K_OPEN;
                    cmd.code = BR_PAREN;
                end
                CH_LSQUARE: begin
                    cmd.kind = K_OPEN;
                    cmd.code = BR_SQUARE;
                end
                CH_LCURLY: begin
                    cmd.kind = K_OPEN;
                    cmd.code = BR_CURLY;
                end
                CH_RPAREN: begin
                    cmd.kind = K_CLOSE;
                    cmd.code = BR_PAREN;
                end
                CH_RSQUARE: begin
                    cmd.kind = K_CLOSE;
                    cmd.code = BR_SQUARE;
                end
                CH_RCURLY: begin
                    cmd.kind = K_CLOSE;
                    cmd.code = BR_CURLY;
                end
                default: cmd.kind = K_OTHER;
            endcase
        end
        return cmd;
    endfunction

    function automatic logic [7:0] opener_char(logic [1:0] code);
        logic [7:0] ch;
        case (code)
            BR_PAREN:  ch = CH_LPAREN;
            BR_SQUARE: ch = CH_LSQUARE;
            BR_CURLY:  ch = CH_LCURLY;
            default:   ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

### rtl/bbc_front.sv
module bbc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  bbc_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output bbc_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);

    bbc_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign full        = (r_cnt == 2'd2);
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= bbc_pkg::classify(i_item);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/bbc_back.sv
module bbc_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  bbc_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    input  logic               pop,
    output logic               empty,
    output bbc_pkg::t_out_item o_result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int LB = bbc_pkg::LINE_BITS;
    localparam int CB = bbc_pkg::COLUMN_BITS;

    // The top of the stack lives in r_top and the entry below it in r_second;
    // the memory holds all entries below the top.
    logic [1:0]          r_mem [STACK_DEPTH];
    logic [1:0]          r_top;
    logic [1:0]          r_second;
    logic [DW-1:0]       r_depth;
    logic [LB-1:0]       r_line;
    logic [CB-1:0]       r_col;
    logic                r_nlp;
    bbc_pkg::t_status    r_err;
    logic [7:0]          r_err_char;
    logic [LB-1:0]       r_err_line;
    logic [CB-1:0]       r_err_col;

    logic [1:0]          n_top;
    logic [DW-1:0]       n_depth;
    logic [LB-1:0]       n_line;
    logic [CB-1:0]       n_col;
    logic                n_nlp;
    bbc_pkg::t_status    n_err;
    logic [7:0]          n_err_char;
    logic [LB-1:0]       n_err_line;
    logic [CB-1:0]       n_err_col;

    logic                w_take;
    logic                w_push;
    logic [DW-1:0]       w_depth_m1;
    logic [DW-1:0]       w_depth_m2;
    logic [LB-1:0]       w_line_inc;
    logic [CB-1:0]       w_col_start;
    logic                w_line_start;
    bbc_pkg::t_out_item  w_res;

    bbc_pkg::t_out_item  r_q [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                w_rd;

    assign w_take     = i_cmd_valid && (r_cnt != 2'd2);
    assign o_cmd_take = w_take;
    assign w_rd       = pop && (r_cnt != 2'd0);
    assign empty      = (r_cnt == 2'd0);
    assign o_result   = r_q[r_rp];

    assign w_depth_m1 = r_depth - DW'(1);
    assign w_depth_m2 = n_depth - DW'(2);
    assign w_line_inc = (r_line == {LB{1'b1}}) ? r_line : r_line + LB'(1);

    always_comb begin
        n_top        = r_top;
        n_depth      = r_depth;
        n_line       = r_line;
        n_col        = r_col;
        n_nlp        = r_nlp;
        n_err        = r_err;
        n_err_char   = r_err_char;
        n_err_line   = r_err_line;
        n_err_col    = r_err_col;
        w_push       = 1'b0;
        w_line_start = r_nlp;
        w_col_start  = r_nlp ? '0 : r_col;
        w_res        = {3'(r_err), r_err_char, r_err_line, r_err_col};
        if (w_take) begin
            if (i_cmd.kind == bbc_pkg::K_EOT) begin
                if (r_err != bbc_pkg::ST_OK) begin
                    w_res = {3'(r_err), r_err_char, r_err_line, r_err_col};
                end else if (r_depth != '0) begin
                    w_res = {3'(bbc_pkg::ST_UNCLOSED), bbc_pkg::opener_char(r_top),
                             r_line, r_col};
                end else begin
                    w_res = {3'(bbc_pkg::ST_MATCHED), 8'd0, r_line, r_col};
                end
                n_depth    = '0;
                n_line     = '0;
                n_col      = '0;
                n_nlp      = 1'b1;
                n_err      = bbc_pkg::ST_OK;
                n_err_char = 8'd0;
                n_err_line = '0;
                n_err_col  = '0;
            end else if (r_err == bbc_pkg::ST_OK) begin
                if (i_cmd.kind == bbc_pkg::K_NEWLINE) begin
                    if (w_line_start) begin
                        n_line = w_line_inc;
                        n_col  = '0;
                    end
                    n_nlp = 1'b1;
                    w_res = {3'(bbc_pkg::ST_OK), 8'd0, n_line, n_col};
                end else begin
                    if (w_line_start) begin
                        n_line = w_line_inc;
                    end
                    n_nlp = 1'b0;
                    n_col = (w_col_start == {CB{1'b1}}) ? w_col_start
                                                        : w_col_start + CB'(1);
                    if (i_cmd.kind == bbc_pkg::K_OPEN) begin
                        if (r_depth == DW'(STACK_DEPTH)) begin
                            n_err = bbc_pkg::ST_OVERFLOW;
                        end else begin
                            w_push  = 1'b1;
                            n_top   = i_cmd.code;
                            n_depth = r_depth + DW'(1);
                        end
                    end else if (i_cmd.kind == bbc_pkg::K_CLOSE) begin
                        if (r_depth == '0) begin
                            n_err = bbc_pkg::ST_CLOSE_EMPTY;
                        end else begin
                            n_top   = r_second;
                            n_depth = w_depth_m1;
                            if (r_top != i_cmd.code) begin
                                n_err = bbc_pkg::ST_MISMATCH;
                            end
                        end
                    end
                    if (n_err != bbc_pkg::ST_OK) begin
                        n_err_char = i_cmd.ch;
                        n_err_line = n_line;
                        n_err_col  = n_col;
                        w_res      = {3'(n_err), i_cmd.ch, n_line, n_col};
                    end else begin
                        w_res = {3'(bbc_pkg::ST_OK), 8'd0, n_line, n_col};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && (r_depth != '0)) begin
            r_mem[w_depth_m1[AW-1:0]] <= r_top;
        end
        if (w_push) begin
            r_second <= r_top;
        end else begin
            r_second <= r_mem[w_depth_m2[AW-1:0]];
        end
        r_top <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_line     <= '0;
            r_col      <= '0;
            r_nlp      <= 1'b1;
            r_err      <= bbc_pkg::ST_OK;
            r_err_char <= 8'd0;
            r_err_line <= '0;
            r_err_col  <= '0;
        end else begin
            r_depth    <= n_depth;
            r_line     <= n_line;
            r_col      <= n_col;
            r_nlp      <= n_nlp;
            r_err      <= n_err;
            r_err_char <= n_err_char;
            r_err_line <= n_err_line;
            r_err_col  <= n_err_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_q[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_take) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            case ({w_take, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/bracket_balance_checker.sv
// Checks bracket balance in a byte stream at one item per clock cycle, sustained while results are
// popped, with one result per item; an item with end_of_text set gives the verdict and clears all state.
// An accepted item is first classified into a two-entry command queue, then carried out against
// the bracket stack and the line and column counters and written to a two-entry result queue. The
// stack top and the entry below it are held in registers, and the stack memory is read ahead into
// r_second, so a pop never waits on it. Either side may stall on its own; full rises when both
// queues fill.
// No clearing pass follows reset: the block takes items in the first cycle after it.
`include "bracket_balance_checker_assert.svh"

module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  bbc_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output bbc_pkg::t_out_item o_result
);

    logic          w_cmd_valid;
    logic          w_cmd_take;
    bbc_pkg::t_cmd w_cmd;
    logic          w_res_ok;
    logic          w_res_err;

    bbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result)
    );

    assign w_res_ok  = o_result.status inside {3'(bbc_pkg::ST_OK), 3'(bbc_pkg::ST_MATCHED)};
    assign w_res_err = o_result.status inside {3'(bbc_pkg::ST_CLOSE_EMPTY),
                                               3'(bbc_pkg::ST_MISMATCH),
                                               3'(bbc_pkg::ST_OVERFLOW),
                                               3'(bbc_pkg::ST_UNCLOSED)};

    `BBC_ASSERT_SAME(a_ok_has_no_char, i_clk, i_rst_n, !empty && w_res_ok, o_result.offending_char == 8'd0)
    `BBC_ASSERT_SAME(a_error_has_char, i_clk, i_rst_n, !empty && w_res_err, o_result.offending_char != 8'd0)
    `BBC_ASSERT_NEXT(a_eot_item_reaches_back, i_clk, i_rst_n, push && !full && i_item.end_of_text, w_cmd_valid)

endmodule

### tb/sv/bracket_balance_checker_tb.sv
`timescale 1ns / 100ps

module bracket_balance_checker_tb;

    localparam int STACK_LIMIT = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_AT_RESULT = 40;
    localparam int HOLD_CYCLES = 300;
    localparam logic [bbc_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [bbc_pkg::COLUMN_BITS-1:0] COLUMN_MAX = '1;

    class bracket_verdict_model;
        logic [1:0] open_codes [STACK_LIMIT];
        int depth;
        logic [bbc_pkg::LINE_BITS-1:0] line;
        logic [bbc_pkg::COLUMN_BITS-1:0] column;
        bit line_pending;
        bbc_pkg::t_status err_status;
        logic [7:0] err_char;
        logic [bbc_pkg::LINE_BITS-1:0] err_line;
        logic [bbc_pkg::COLUMN_BITS-1:0] err_column;
        bbc_pkg::t_out_item expected_verdicts[$];
        int mismatch_count;
        int checked_count;

        function new();
            mismatch_count = 0;
            checked_count = 0;
            clear();
        endfunction

        static function logic [7:0] bracket_char(logic [1:0] code, bit closing);
            case (code)
                bbc_pkg::BR_PAREN:  return closing ? bbc_pkg::CH_RPAREN : bbc_pkg::CH_LPAREN;
                bbc_pkg::BR_SQUARE: return closing ? bbc_pkg::CH_RSQUARE : bbc_pkg::CH_LSQUARE;
                default:            return closing ? bbc_pkg::CH_RCURLY : bbc_pkg::CH_LCURLY;
            endcase
        endfunction

        function void clear();
            depth = 0;
            line = '0;
            column = '0;
            line_pending = 1'b1;
            err_status = bbc_pkg::ST_OK;
            err_char = '0;
            err_line = '0;
            err_column = '0;
        endfunction

        function void raise_error(bbc_pkg::t_status code, logic [7:0] ch);
            err_status = code;
            err_char = ch;
            err_line = line;
            err_column = column;
        endfunction

        function bbc_pkg::t_out_item verdict(bbc_pkg::t_status st, logic [7:0] ch,
                                             logic [bbc_pkg::LINE_BITS-1:0] ln,
                                             logic [bbc_pkg::COLUMN_BITS-1:0] col);
            bbc_pkg::t_out_item res;
            res.status = st;
            res.offending_char = ch;
            res.line_no = ln;
            res.column_no = col;
            return res;
        endfunction

        function void note_item(bbc_pkg::t_in_item it);
            bbc_pkg::t_out_item res;
            logic [7:0] ch;
            logic [1:0] code;
            bit is_open;
            bit is_close;
            ch = it.text_byte;
            is_open = 1'b0;
            is_close = 1'b0;
            code = bbc_pkg::BR_PAREN;
            if (it.end_of_text) begin
                if (err_status != bbc_pkg::ST_OK)
                    res = verdict(err_status, err_char, err_line, err_column);
                else if (depth > 0)
                    res = verdict(bbc_pkg::ST_UNCLOSED, bracket_char(open_codes[depth-1], 1'b0),
                                  line, column);
                else
                    res = verdict(bbc_pkg::ST_MATCHED, 8'd0, line, column);
                clear();
            end else if (err_status != bbc_pkg::ST_OK) begin
                res = verdict(err_status, err_char, err_line, err_column);
            end else if (ch == bbc_pkg::CH_NEWLINE) begin
                if (line_pending) begin
                    if (line != LINE_MAX) line++;
                    column = '0;
                end
                line_pending = 1'b1;
                res = verdict(bbc_pkg::ST_OK, 8'd0, line, column);
            end else begin
                if (line_pending) begin
                    if (line != LINE_MAX) line++;
                    column = '0;
                    line_pending = 1'b0;
                end
                if (column != COLUMN_MAX) column++;
                case (ch)
                    bbc_pkg::CH_LPAREN: begin
                        is_open = 1'b1;
                        code = bbc_pkg::BR_PAREN;
                    end
                    bbc_pkg::CH_LSQUARE: begin
                        is_open = 1'b1;
                        code = bbc_pkg::BR_SQUARE;
                    end
                    bbc_pkg::CH_LCURLY: begin
                        is_open = 1'b1;
                        code = bbc_pkg::BR_CURLY;
                    end
                    bbc_pkg::CH_RPAREN: begin
                        is_close = 1'b1;
                        code = bbc_pkg::BR_PAREN;
                    end
                    bbc_pkg::CH_RSQUARE: begin
                        is_close = 1'b1;
                        code = bbc_pkg::BR_SQUARE;
                    end
                    bbc_pkg::CH_RCURLY: begin
                        is_close = 1'b1;
                        code = bbc_pkg::BR_CURLY;
                    end
                    default: ;
                endcase
                if (is_open) begin
                    if (depth >= STACK_LIMIT) begin
                        raise_error(bbc_pkg::ST_OVERFLOW, ch);
                    end else begin
                        open_codes[depth] = code;
                        depth++;
                    end
                end else if (is_close) begin
                    if (depth == 0) begin
                        raise_error(bbc_pkg::ST_CLOSE_EMPTY, ch);
                    end else begin
                        depth--;
                        if (open_codes[depth] != code) raise_error(bbc_pkg::ST_MISMATCH, ch);
                    end
                end
                if (err_status != bbc_pkg::ST_OK)
                    res = verdict(err_status, err_char, err_line, err_column);
                else
                    res = verdict(bbc_pkg::ST_OK, 8'd0, line, column);
            end
            expected_verdicts.push_back(res);
        endfunction

        function void report(string what, bbc_pkg::t_out_item want, bbc_pkg::t_out_item got);
            if (mismatch_count < 10)
                $display({"result %0d %s: expected status %0d char %02h line %0d col %0d,",
                          " got status %0d char %02h line %0d col %0d"},
                         checked_count, what, want.status, want.offending_char, want.line_no,
                         want.column_no, got.status, got.offending_char, got.line_no,
                         got.column_no);
            mismatch_count++;
        endfunction

        function void check_result(bbc_pkg::t_out_item got);
            bbc_pkg::t_out_item want;
            if (expected_verdicts.size() == 0) begin
                report("unexpected", '0, got);
            end else begin
                want = expected_verdicts.pop_front();
                if (got.status != want.status)
                    report("status mismatch", want, got);
                else if (got.offending_char != want.offending_char)
                    report("offending_char mismatch", want, got);
                else if (got.line_no != want.line_no)
                    report("line_no mismatch", want, got);
                else if (got.column_no != want.column_no)
                    report("column_no mismatch", want, got);
            end
            checked_count++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    bbc_pkg::t_in_item i_item = '0;
    logic empty;
    logic pop = 1'b0;
    bbc_pkg::t_out_item o_result;

    bracket_verdict_model verdicts = new();
    logic [7:0] text_q[$];
    int items_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit burst_mode = 1'b0;
    bit steady_send = 1'b0;
    bit steady_recv = 1'b0;

    bracket_balance_checker u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_filler();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == bbc_pkg::CH_NEWLINE || b == bbc_pkg::CH_LPAREN ||
               b == bbc_pkg::CH_RPAREN || b == bbc_pkg::CH_LSQUARE ||
               b == bbc_pkg::CH_RSQUARE || b == bbc_pkg::CH_LCURLY ||
               b == bbc_pkg::CH_RCURLY)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_item(input bbc_pkg::t_in_item it);
        int gap;
        gap = (burst_mode || steady_send) ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        verdicts.note_item(it);
        items_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        bbc_pkg::t_in_item it;
        it.text_byte = ch;
        it.end_of_text = 1'b0;
        send_item(it);
    endtask

    task automatic send_eot();
        bbc_pkg::t_in_item it;
        it.text_byte = 8'($urandom_range(0, 255));
        it.end_of_text = 1'b1;
        send_item(it);
    endtask

    task automatic build_random_text();
        logic [1:0] nest[$];
        logic [1:0] code;
        int style;
        int target;
        int k;
        style = $urandom_range(0, 99);
        if (style < 3) return;
        if (style < 15) begin
            repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 9) == 0) begin
            target = $urandom_range(60, 66);
            repeat (target) begin
                code = 2'($urandom_range(0, 2));
                nest.push_back(code);
                text_q.push_back(bracket_verdict_model::bracket_char(code, 1'b0));
            end
        end else begin
            target = $urandom_range(1, 8);
        end
        repeat ($urandom_range(1, 30)) begin
            k = $urandom_range(0, 9);
            if (k < 4 && nest.size() < target) begin
                code = 2'($urandom_range(0, 2));
                nest.push_back(code);
                text_q.push_back(bracket_verdict_model::bracket_char(code, 1'b0));
            end else if (k < 7 && nest.size() > 0) begin
                text_q.push_back(bracket_verdict_model::bracket_char(nest.pop_back(), 1'b1));
            end else if (k == 7) begin
                text_q.push_back(bbc_pkg::CH_NEWLINE);
            end else begin
                text_q.push_back(pick_filler());
            end
        end
        if (style < 22) return;
        while (nest.size() > 0)
            text_q.push_back(bracket_verdict_model::bracket_char(nest.pop_back(), 1'b1));
        if (style < 28) begin
            code = 2'($urandom_range(0, 2));
            text_q.push_back(bracket_verdict_model::bracket_char(code, 1'b1));
        end else if (style < 36) begin
            k = $urandom_range(0, text_q.size() - 1);
            code = 2'($urandom_range(0, 2));
            text_q[k] = bracket_verdict_model::bracket_char(code, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("bracket_balance_checker regression: fail");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results_seen % 64 == 0) steady_recv = ($urandom_range(0, 3) == 0);
            if (results_seen == HOLD_AT_RESULT)
                gap = HOLD_CYCLES;
            else
                gap = (burst_mode || steady_recv) ? 0 : pick_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            verdicts.check_result(o_result);
            results_seen++;
        end
    end

    initial begin : stimulus
        int start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_eot();
        send_char(bbc_pkg::CH_LPAREN);
        send_eot();
        send_char(bbc_pkg::CH_RPAREN);
        send_char(8'h61);
        send_eot();
        send_char(bbc_pkg::CH_LSQUARE);
        send_char(bbc_pkg::CH_RCURLY);
        send_char(bbc_pkg::CH_RSQUARE);
        send_eot();
        send_char(bbc_pkg::CH_NEWLINE);
        send_char(bbc_pkg::CH_NEWLINE);
        send_char(bbc_pkg::CH_LCURLY);
        send_char(8'h00);
        send_char(8'h0D);
        send_char(bbc_pkg::CH_NEWLINE);
        send_char(8'hFF);
        send_char(bbc_pkg::CH_RCURLY);
        send_char(bbc_pkg::CH_LPAREN);
        send_char(bbc_pkg::CH_LSQUARE);
        send_char(bbc_pkg::CH_RSQUARE);
        send_char(bbc_pkg::CH_RPAREN);
        send_eot();

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            steady_send = ($urandom_range(0, 3) == 0);
            build_random_text();
            while (text_q.size() > 0) send_char(text_q.pop_front());
            send_eot();
        end
        steady_send = 1'b0;

        burst_mode = 1'b1;
        repeat (STACK_LIMIT) send_char(bbc_pkg::CH_LCURLY);
        send_char(bbc_pkg::CH_LPAREN);
        send_char(bbc_pkg::CH_RPAREN);
        send_eot();
        send_char(bbc_pkg::CH_NEWLINE);
        send_char(pick_filler());
        send_char(bbc_pkg::CH_LSQUARE);
        send_eot();
        burst_mode = 1'b0;

        push <= 1'b0;
        while (verdicts.expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (verdicts.mismatch_count == 0 && verdicts.expected_verdicts.size() == 0)
            $display("bracket_balance_checker regression: pass");
        else
            $display("bracket_balance_checker regression: fail");
        $finish;
    end

endmodule
